// ===== rtl/lrse_pkg.sv =====
package lrse_pkg;

  localparam int STATE_COUNT     = 256;
  localparam int SYMBOL_COUNT    = 64;
  localparam int STACK_DEPTH     = 64;
  localparam int MAX_RULE_LENGTH = 15;
  localparam int CHAIN_LIMIT     = 63;

  localparam int STW  = 8;
  localparam int SYW  = 6;
  localparam int SPW  = 7;
  localparam int IDXW = STW + SYW;
  localparam int TBL_DEPTH = STATE_COUNT * SYMBOL_COUNT;
  localparam int STK_AW = $clog2(STACK_DEPTH);

  typedef enum logic [1:0] {
    OP_TOKEN = 2'd0, OP_WR_ACTION = 2'd1, OP_WR_GOTO = 2'd2, OP_RESTART = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0, KIND_SHIFT = 2'd1, KIND_REDUCE = 2'd2, KIND_ACCEPT = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    EV_SHIFT = 3'd0, EV_REDUCE = 3'd1, EV_ACCEPT = 3'd2, EV_SYNTAX = 3'd3,
    EV_NOGOTO = 3'd4, EV_OVERFLOW = 3'd5, EV_CHAIN = 3'd6
  } event_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] table_state;
    logic [5:0] table_symbol;
    logic [5:0] token_id;
    logic [1:0] entry_kind;
    logic [7:0] entry_target;
    logic [3:0] entry_rule_length;
    logic [5:0] entry_rule_lhs;
  } in_item_t;

  typedef struct packed {
    logic [2:0] event_kind;
    logic [7:0] state_after;
    logic [5:0] reduced_lhs;
    logic [3:0] reduced_length;
    logic [5:0] token_echo;
    logic [6:0] stack_depth;
    logic       last_of_run;
  } out_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] target;
    logic [3:0] len;
    logic [5:0] lhs;
  } act_entry_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] target;
  } goto_entry_t;

endpackage

// ===== rtl/lr_shift_reduce_engine.sv =====
// Path: a token's first event goes through the action read (ACT) and the emit step (EMIT);
//   a reduce event also goes through the exposed state read (POP) and the goto read (GOTO).
// Throughput: one request at a time; the input stalls until a token's run ends, while
//   table writes and restart are taken in IDLE without leaving it; a stalled
//   output holds the run in the emit step.
// Reset: synchronous; a sweep of all 16384 entries clears both tables while the input stalls.
module lr_shift_reduce_engine (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  lrse_pkg::in_item_t in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output lrse_pkg::out_item_t out_data
);
  import lrse_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_ACT, S_POP, S_GOTO, S_EMIT
  } st_t;

  st_t             st_r, st_nxt;
  logic [IDXW-1:0] clr_r, clr_nxt;
  logic [SPW-1:0]  sp_r, sp_nxt;
  logic [STW-1:0]  top_r, top_nxt;
  logic            halted_r, halted_nxt;
  logic [SYW-1:0]  tok_r, tok_nxt;
  logic [5:0]      chain_r, chain_nxt;
  logic [5:0]      rule_lhs_r, rule_lhs_nxt;
  logic [3:0]      rule_len_r, rule_len_nxt;
  out_item_t       ev_r, ev_nxt;
  logic            out_valid_r, out_valid_nxt;
  out_item_t       out_data_r, out_data_nxt;

  // memories: tables indexed by {state, symbol}, state stack by depth
  act_entry_t     act_mem [TBL_DEPTH];
  goto_entry_t    goto_mem [TBL_DEPTH];
  logic [STW-1:0] stk_mem [STACK_DEPTH];
  act_entry_t     act_rd_r;
  goto_entry_t    goto_rd_r;
  logic [STW-1:0] stk_rd_r;

  logic              act_we, goto_we, stk_we;
  logic [IDXW-1:0]   tbl_wa, act_ra, goto_ra;
  act_entry_t        act_wd;
  goto_entry_t       goto_wd;
  logic [STK_AW-1:0] stk_wa, stk_ra;
  logic [STW-1:0]    stk_wd;

  always_ff @(posedge clk) begin
    if (act_we) act_mem[tbl_wa] <= act_wd;
    if (goto_we) goto_mem[tbl_wa] <= goto_wd;
    if (stk_we) stk_mem[stk_wa] <= stk_wd;
    act_rd_r  <= act_mem[act_ra];
    goto_rd_r <= goto_mem[goto_ra];
    stk_rd_r  <= stk_mem[stk_ra];
  end

  logic in_acc;
  logic out_free;
  assign in_stall  = (st_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // depth left after a reduce pops its rule
  logic [SPW-1:0] sp_pop;
  assign sp_pop = sp_r - SPW'(act_rd_r.len);

  function automatic out_item_t mk_event(event_t kind, logic [STW-1:0] st,
                                         logic [5:0] lhs, logic [3:0] len,
                                         logic [SYW-1:0] tok, logic [SPW-1:0] dp,
                                         logic last);
    out_item_t e;
    e.event_kind     = kind;
    e.state_after    = st;
    e.reduced_lhs    = lhs;
    e.reduced_length = len;
    e.token_echo     = tok;
    e.stack_depth    = dp;
    e.last_of_run    = last;
    return e;
  endfunction

  // Run sequence: IDLE (action read issued) -> ACT, which ends the run with shift,
  // accept or an error, or pops for a reduce -> POP (exposed state ready, goto read
  // issued) -> GOTO -> EMIT. After a reduce is emitted, EMIT has already issued the
  // action read for the new top, so advance straight to ACT.
  always_comb begin
    st_nxt        = st_r;
    clr_nxt       = clr_r;
    sp_nxt        = sp_r;
    top_nxt       = top_r;
    halted_nxt    = halted_r;
    tok_nxt       = tok_r;
    chain_nxt     = chain_r;
    rule_lhs_nxt  = rule_lhs_r;
    rule_len_nxt  = rule_len_r;
    ev_nxt        = ev_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;

    act_we  = 1'b0;
    goto_we = 1'b0;
    stk_we  = 1'b0;
    tbl_wa  = {in_data.table_state, in_data.table_symbol};
    act_wd  = '{kind: in_data.entry_kind, target: in_data.entry_target,
                len: in_data.entry_rule_length, lhs: in_data.entry_rule_lhs};
    goto_wd = '{valid: (in_data.entry_kind != KIND_NONE), target: in_data.entry_target};
    stk_wa  = sp_r[STK_AW-1:0];
    stk_wd  = '0;
    act_ra  = {top_r, tok_r};
    goto_ra = {stk_rd_r, rule_lhs_r};
    stk_ra  = sp_pop[STK_AW-1:0] - STK_AW'(1);

    unique case (st_r)
      S_CLEAR: begin
        // wipe one entry of each table per cycle; keep state 0 at the stack bottom
        act_we  = 1'b1;
        goto_we = 1'b1;
        stk_we  = 1'b1;
        tbl_wa  = clr_r;
        act_wd  = '0;
        goto_wd = '0;
        stk_wa  = '0;
        clr_nxt = clr_r + IDXW'(1);
        if (&clr_r) st_nxt = S_IDLE;
      end
      S_IDLE: begin
        act_ra = {top_r, in_data.token_id};
        if (in_acc) begin
          unique case (opcode_t'(in_data.opcode))
            OP_WR_ACTION: act_we = 1'b1;
            OP_WR_GOTO:   goto_we = 1'b1;
            OP_RESTART: begin
              sp_nxt     = SPW'(1);
              top_nxt    = '0;
              halted_nxt = 1'b0;
            end
            OP_TOKEN: begin
              // drop tokens while halted
              if (!halted_r) begin
                tok_nxt   = in_data.token_id;
                chain_nxt = '0;
                st_nxt    = S_ACT;
              end
            end
          endcase
        end
      end
      S_ACT: begin
        // assume the run ends here and halts; a shift that fits and a reduce that pops undo it
        st_nxt     = S_EMIT;
        halted_nxt = 1'b1;
        ev_nxt     = mk_event(EV_SYNTAX, top_r, '0, '0, tok_r, sp_r, 1'b1);
        unique case (kind_t'(act_rd_r.kind))
          KIND_NONE: ;
          KIND_SHIFT: begin
            if (sp_r >= SPW'(STACK_DEPTH)) begin
              ev_nxt.event_kind = EV_OVERFLOW;
            end else begin
              stk_we     = 1'b1;
              stk_wd     = act_rd_r.target;
              sp_nxt     = sp_r + SPW'(1);
              top_nxt    = act_rd_r.target;
              halted_nxt = 1'b0;
              ev_nxt     = mk_event(EV_SHIFT, act_rd_r.target, '0, '0, tok_r,
                                    sp_r + SPW'(1), 1'b1);
            end
          end
          KIND_ACCEPT: ev_nxt.event_kind = EV_ACCEPT;
          KIND_REDUCE: begin
            priority if (chain_r == 6'(CHAIN_LIMIT)) begin
              ev_nxt.event_kind = EV_CHAIN;
            end else if (SPW'(act_rd_r.len) >= sp_r) begin
              // rule would pop the whole stack
              ev_nxt = mk_event(EV_NOGOTO, top_r, act_rd_r.lhs, act_rd_r.len, tok_r,
                                sp_r, 1'b1);
            end else begin
              // pop and fetch the exposed state
              halted_nxt   = 1'b0;
              sp_nxt       = sp_pop;
              rule_lhs_nxt = act_rd_r.lhs;
              rule_len_nxt = act_rd_r.len;
              st_nxt       = S_POP;
            end
          end
        endcase
      end
      S_POP: begin
        top_nxt = stk_rd_r;
        st_nxt  = S_GOTO;
      end
      S_GOTO: begin
        st_nxt = S_EMIT;
        priority if (!goto_rd_r.valid) begin
          halted_nxt = 1'b1;
          ev_nxt = mk_event(EV_NOGOTO, top_r, rule_lhs_r, rule_len_r, tok_r, sp_r, 1'b1);
        end else if (sp_r >= SPW'(STACK_DEPTH)) begin
          halted_nxt = 1'b1;
          ev_nxt = mk_event(EV_OVERFLOW, top_r, rule_lhs_r, rule_len_r, tok_r, sp_r,
                            1'b1);
        end else begin
          // push the goto target and keep the run going
          stk_we    = 1'b1;
          stk_wd    = goto_rd_r.target;
          sp_nxt    = sp_r + SPW'(1);
          top_nxt   = goto_rd_r.target;
          chain_nxt = chain_r + 6'(1);
          ev_nxt    = mk_event(EV_REDUCE, goto_rd_r.target, rule_lhs_r, rule_len_r,
                               tok_r, sp_r + SPW'(1), 1'b0);
        end
      end
      S_EMIT: begin
        // hold the event until the output register frees
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = ev_r;
          st_nxt        = ev_r.last_of_run ? S_IDLE : S_ACT;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_CLEAR;
      clr_r       <= '0;
      sp_r        <= SPW'(1);
      top_r       <= '0;
      halted_r    <= 1'b0;
      tok_r       <= '0;
      chain_r     <= '0;
      rule_lhs_r  <= '0;
      rule_len_r  <= '0;
      ev_r        <= '0;
      out_valid_r <= 1'b0;
      out_data_r  <= '0;
    end else begin
      st_r        <= st_nxt;
      clr_r       <= clr_nxt;
      sp_r        <= sp_nxt;
      top_r       <= top_nxt;
      halted_r    <= halted_nxt;
      tok_r       <= tok_nxt;
      chain_r     <= chain_nxt;
      rule_lhs_r  <= rule_lhs_nxt;
      rule_len_r  <= rule_len_nxt;
      ev_r        <= ev_nxt;
      out_valid_r <= out_valid_nxt;
      out_data_r  <= out_data_nxt;
    end
  end

  a_sp_range: assert property (@(posedge clk) disable iff (!rst_n)
    (sp_r != '0) && (sp_r <= SPW'(STACK_DEPTH)));
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> out_valid_r && $stable(out_data_r));
  a_clear_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_CLEAR) |-> in_stall);
  a_chain_bound: assert property (@(posedge clk) disable iff (!rst_n)
    chain_r <= 6'(CHAIN_LIMIT));

endmodule
